// File: sv/slu_pkg.sv
// Shared types and constants of the serial line unit registers.
`default_nettype none
package slu_pkg;

  // Event codes carried by the func field of a command transaction.
  typedef enum logic [1:0] {
    FUNC_READ    = 2'd0,
    FUNC_WRITE   = 2'd1,
    FUNC_RX_CHAR = 2'd2,
    FUNC_TX_DONE = 2'd3
  } func_t;

  // Address bit positions.
  localparam int unsigned ADDR_SIDE_BIT = 2;  // 0 receiver, 1 transmitter
  localparam int unsigned ADDR_BUF_BIT  = 1;  // 0 status, 1 buffer
  localparam int unsigned ADDR_ODD_BIT  = 0;  // odd byte

  // Status register bit positions.
  localparam int unsigned STAT_DONE_BIT = 7;
  localparam int unsigned STAT_IE_BIT   = 6;

  localparam logic [7:0] MASK8 = 8'o377;
  localparam logic [7:0] MASK7 = 8'o177;

  typedef struct packed {
    func_t       func;
    logic [2:0]  addr;
    logic [15:0] write_data;
    logic [7:0]  rx_char;
    logic        rx_break;
  } cmd_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        rx_irq;
    logic        tx_irq;
    logic        tx_start;
    logic        tx_char_valid;
    logic [7:0]  tx_char;
  } rsp_t;

endpackage
`default_nettype wire

// File: sv/slu_if.sv
// Valid/ready channel interfaces for commands and responses.
`default_nettype none
interface slu_cmd_if;
  logic                valid;
  logic                ready;
  slu_pkg::func_t      func;
  logic [2:0]          addr;
  logic [15:0]         write_data;
  logic [7:0]          rx_char;
  logic                rx_break;

  modport source (output valid, func, addr, write_data, rx_char, rx_break, input ready);
  modport sink   (input valid, func, addr, write_data, rx_char, rx_break, output ready);
endinterface

interface slu_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        rx_irq;
  logic        tx_irq;
  logic        tx_start;
  logic        tx_char_valid;
  logic [7:0]  tx_char;

  modport source (output valid, read_data, rx_irq, tx_irq, tx_start, tx_char_valid, tx_char,
                  input ready);
  modport sink   (input valid, read_data, rx_irq, tx_irq, tx_start, tx_char_valid, tx_char,
                  output ready);
endinterface
`default_nettype wire

// File: sv/slu_core.sv
// Receiver and transmitter status, buffer and interrupt state with its update logic.
`default_nettype none
module slu_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire slu_pkg::cmd_t cmd,
  input  wire logic          eight_bit_mode,
  output slu_pkg::rsp_t      rsp
);
  import slu_pkg::*;

  logic [7:0] rx_buffer, rx_buffer_next;
  logic       rx_done, rx_done_next;
  logic       rx_int_enable, rx_int_enable_next;
  logic       rx_int_request, rx_int_request_next;
  logic [7:0] tx_buffer, tx_buffer_next;
  logic       tx_done, tx_done_next;
  logic       tx_int_enable, tx_int_enable_next;
  logic       tx_int_request, tx_int_request_next;
  logic       tx_pending, tx_pending_next;

  logic [7:0] char_mask;
  logic       tx_side, buf_sel, odd, wr_ie;

  assign char_mask = eight_bit_mode ? MASK8 : MASK7;
  assign tx_side   = cmd.addr[ADDR_SIDE_BIT];
  assign buf_sel   = cmd.addr[ADDR_BUF_BIT];
  assign odd       = cmd.addr[ADDR_ODD_BIT];
  assign wr_ie     = cmd.write_data[STAT_IE_BIT];

  always_comb begin
    rx_buffer_next      = rx_buffer;
    rx_done_next        = rx_done;
    rx_int_enable_next  = rx_int_enable;
    rx_int_request_next = rx_int_request;
    tx_buffer_next      = tx_buffer;
    tx_done_next        = tx_done;
    tx_int_enable_next  = tx_int_enable;
    tx_int_request_next = tx_int_request;
    tx_pending_next     = tx_pending;
    rsp                 = '0;

    unique case (cmd.func)
      FUNC_READ: begin
        if (!tx_side) begin
          if (!buf_sel) begin
            rsp.read_data[STAT_DONE_BIT] = rx_done;
            rsp.read_data[STAT_IE_BIT]   = rx_int_enable;
          end else begin
            rx_done_next        = 1'b0;
            rx_int_request_next = 1'b0;
            rsp.read_data       = {8'd0, rx_buffer};
          end
        end else begin
          if (!buf_sel) begin
            rsp.read_data[STAT_DONE_BIT] = tx_done;
            rsp.read_data[STAT_IE_BIT]   = tx_int_enable;
          end else begin
            rsp.read_data = {8'd0, tx_buffer};
          end
        end
      end
      FUNC_WRITE: begin
        if (!buf_sel) begin
          // Even-byte status write: clearing enable drops the request; setting it while
          // done is already set raises the request.
          if (!odd) begin
            if (!tx_side) begin
              if (!wr_ie) rx_int_request_next = 1'b0;
              else if (rx_done && !rx_int_enable) rx_int_request_next = 1'b1;
              rx_int_enable_next = wr_ie;
            end else begin
              if (!wr_ie) tx_int_request_next = 1'b0;
              else if (tx_done && !tx_int_enable) tx_int_request_next = 1'b1;
              tx_int_enable_next = wr_ie;
            end
          end
        end else if (tx_side) begin
          // An odd-byte buffer write keeps the old character but still starts.
          if (!odd) tx_buffer_next = cmd.write_data[7:0];
          tx_done_next        = 1'b0;
          tx_int_request_next = 1'b0;
          tx_pending_next     = 1'b1;
          rsp.tx_start        = 1'b1;
        end
      end
      FUNC_RX_CHAR: begin
        rx_buffer_next = cmd.rx_break ? 8'd0 : (cmd.rx_char & char_mask);
        rx_done_next   = 1'b1;
        if (rx_int_enable) rx_int_request_next = 1'b1;
      end
      FUNC_TX_DONE: begin
        if (tx_pending) begin
          tx_pending_next   = 1'b0;
          tx_done_next      = 1'b1;
          if (tx_int_enable) tx_int_request_next = 1'b1;
          rsp.tx_char_valid = 1'b1;
          rsp.tx_char       = tx_buffer & char_mask;
        end
      end
      default: ;
    endcase

    rsp.rx_irq = rx_int_request_next;
    rsp.tx_irq = tx_int_request_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_buffer      <= 8'd0;
      rx_done        <= 1'b0;
      rx_int_enable  <= 1'b0;
      rx_int_request <= 1'b0;
      tx_buffer      <= 8'd0;
      tx_done        <= 1'b1;
      tx_int_enable  <= 1'b0;
      tx_int_request <= 1'b0;
      tx_pending     <= 1'b0;
    end else if (fire) begin
      rx_buffer      <= rx_buffer_next;
      rx_done        <= rx_done_next;
      rx_int_enable  <= rx_int_enable_next;
      rx_int_request <= rx_int_request_next;
      tx_buffer      <= tx_buffer_next;
      tx_done        <= tx_done_next;
      tx_int_enable  <= tx_int_enable_next;
      tx_int_request <= tx_int_request_next;
      tx_pending     <= tx_pending_next;
    end
  end

`ifndef SYNTH
  // A request is only ever held while its side is done and enabled.
  a_rx_irq_cause: assert property (@(posedge clk) disable iff (rst)
    rx_int_request |-> (rx_done && rx_int_enable))
    else $error("rx interrupt request without done and enable");

  a_tx_irq_cause: assert property (@(posedge clk) disable iff (rst)
    tx_int_request |-> (tx_done && tx_int_enable))
    else $error("tx interrupt request without done and enable");

  a_tx_pending_not_done: assert property (@(posedge clk) disable iff (rst)
    tx_pending |-> !tx_done)
    else $error("transfer pending while transmitter reports done");

  a_tx_finish: assert property (@(posedge clk) disable iff (rst)
    (fire && cmd.func == FUNC_TX_DONE && tx_pending) |=> (tx_done && !tx_pending))
    else $error("finished transfer did not set done");

  a_rx_receive: assert property (@(posedge clk) disable iff (rst)
    (fire && cmd.func == FUNC_RX_CHAR) |=> rx_done)
    else $error("received character did not set done");
`endif

endmodule
`default_nettype wire

// File: sv/serial_line_unit_registers_top.sv
// Top level of the serial line unit registers: channel registers and mode register.
`default_nettype none
// Serial line register block. Each command transaction (bus read, bus write,
// received character, or transmit-finished event) produces exactly one
// response transaction carrying read data, both interrupt levels and the
// transmit start and character outputs. The block takes one command per
// cycle: a command is captured in an input register, its flag updates are
// evaluated in one pass of short logic against the register state, and the
// response lands in an output register once that register is free. The
// output register lets the next command be accepted while a response still
// waits; the throughput is one transaction per cycle unless the response
// side stalls. The eight-bit mode register is written through cfg_wr_en and
// cfg_wr_data and should only change while no command is in flight.
module serial_line_unit_registers_top (
  input  wire logic clk,
  input  wire logic rst,
  slu_cmd_if.sink   cmd,
  slu_rsp_if.source rsp,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data
);
  import slu_pkg::*;

  cmd_t cmd_q;
  logic cmd_vld;
  rsp_t rsp_q;
  logic rsp_vld;
  rsp_t rsp_calc;
  logic eight_bit_mode;
  logic adv;

  // The staged command moves into the response register when it is free.
  assign adv       = cmd_vld && (!rsp_vld || rsp.ready);
  assign cmd.ready = !cmd_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vld        <= 1'b0;
      rsp_vld        <= 1'b0;
      eight_bit_mode <= 1'b0;
    end else begin
      if (cfg_wr_en) eight_bit_mode <= cfg_wr_data;
      if (cmd.valid && cmd.ready) cmd_vld <= 1'b1;
      else if (adv) cmd_vld <= 1'b0;
      if (adv) rsp_vld <= 1'b1;
      else if (rsp.ready) rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_q.func       <= cmd.func;
      cmd_q.addr       <= cmd.addr;
      cmd_q.write_data <= cmd.write_data;
      cmd_q.rx_char    <= cmd.rx_char;
      cmd_q.rx_break   <= cmd.rx_break;
    end
    if (adv) rsp_q <= rsp_calc;
  end

  slu_core u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (adv),
    .cmd            (cmd_q),
    .eight_bit_mode (eight_bit_mode),
    .rsp            (rsp_calc)
  );

  assign rsp.valid         = rsp_vld;
  assign rsp.read_data     = rsp_q.read_data;
  assign rsp.rx_irq        = rsp_q.rx_irq;
  assign rsp.tx_irq        = rsp_q.tx_irq;
  assign rsp.tx_start      = rsp_q.tx_start;
  assign rsp.tx_char_valid = rsp_q.tx_char_valid;
  assign rsp.tx_char       = rsp_q.tx_char;

endmodule
`default_nettype wire

// File: dv/slu_reg_checker.sv
`timescale 1ns / 1ps
// Checker for the serial line unit registers: mirrors the register state and checks each response.
module slu_reg_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  slu_cmd_if   cmd,
  slu_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding
);
  import slu_pkg::*;

  // Mirror of the block's register state.
  logic       eight_bit;
  logic [7:0] rx_buf, tx_buf;
  logic       rx_done, rx_ie, rx_irq;
  logic       tx_done, tx_ie, tx_irq, tx_busy;

  rsp_t reply_q[$];
  int   errors = 0;

  function automatic logic [7:0] line_mask();
    return eight_bit ? MASK8 : MASK7;
  endfunction

  // Even-byte status write: returns {enable, request}.
  function automatic logic [1:0] status_update(logic [15:0] data, logic done, logic ie,
                                               logic irq);
    logic en;
    en = data[STAT_IE_BIT];
    if (!en) begin
      irq = 1'b0;
    end else if (done && !ie) begin
      irq = 1'b1;
    end
    return {en, irq};
  endfunction

  // Applies one event to the mirrored registers and returns the response it causes.
  function automatic rsp_t serve_event(cmd_t c);
    rsp_t r;
    logic tx_side, buf_sel, odd;
    r       = '0;
    tx_side = c.addr[ADDR_SIDE_BIT];
    buf_sel = c.addr[ADDR_BUF_BIT];
    odd     = c.addr[ADDR_ODD_BIT];
    case (c.func)
      FUNC_READ: begin
        if (!tx_side && !buf_sel) begin
          r.read_data[STAT_DONE_BIT] = rx_done;
          r.read_data[STAT_IE_BIT]   = rx_ie;
        end else if (!tx_side) begin
          rx_done     = 1'b0;
          rx_irq      = 1'b0;
          r.read_data = {8'h00, rx_buf};
        end else if (!buf_sel) begin
          r.read_data[STAT_DONE_BIT] = tx_done;
          r.read_data[STAT_IE_BIT]   = tx_ie;
        end else begin
          r.read_data = {8'h00, tx_buf};
        end
      end
      FUNC_WRITE: begin
        if (!buf_sel) begin
          // Odd-byte status writes leave everything alone.
          if (!odd && !tx_side) begin
            {rx_ie, rx_irq} = status_update(c.write_data, rx_done, rx_ie, rx_irq);
          end else if (!odd) begin
            {tx_ie, tx_irq} = status_update(c.write_data, tx_done, tx_ie, tx_irq);
          end
        end else if (tx_side) begin
          if (!odd) begin
            tx_buf = c.write_data[7:0];
          end
          tx_done    = 1'b0;
          tx_irq     = 1'b0;
          tx_busy    = 1'b1;
          r.tx_start = 1'b1;
        end
      end
      FUNC_RX_CHAR: begin
        rx_buf  = c.rx_break ? 8'h00 : (c.rx_char & line_mask());
        rx_done = 1'b1;
        if (rx_ie) begin
          rx_irq = 1'b1;
        end
      end
      FUNC_TX_DONE: begin
        if (tx_busy) begin
          tx_busy         = 1'b0;
          tx_done         = 1'b1;
          if (tx_ie) begin
            tx_irq = 1'b1;
          end
          r.tx_char_valid = 1'b1;
          r.tx_char       = tx_buf & line_mask();
        end
      end
    endcase
    r.rx_irq = rx_irq;
    r.tx_irq = tx_irq;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cmd_t seen;
    rsp_t want;
    if (rst) begin
      eight_bit = 1'b0;
      rx_buf    = '0;
      rx_done   = 1'b0;
      rx_ie     = 1'b0;
      rx_irq    = 1'b0;
      tx_buf    = '0;
      tx_done   = 1'b1;
      tx_ie     = 1'b0;
      tx_irq    = 1'b0;
      tx_busy   = 1'b0;
      reply_q.delete();
    end else begin
      if (cfg_wr_en) begin
        eight_bit = cfg_wr_data;
      end
      if (cmd.valid && cmd.ready) begin
        seen.func       = cmd.func;
        seen.addr       = cmd.addr;
        seen.write_data = cmd.write_data;
        seen.rx_char    = cmd.rx_char;
        seen.rx_break   = cmd.rx_break;
        reply_q.push_back(serve_event(seen));
      end
      if (rsp.valid && rsp.ready) begin
        if (reply_q.size() == 0) begin
          $error("response transaction with no command waiting for it");
          errors++;
        end else begin
          want = reply_q.pop_front();
          check_field("read_data", want.read_data, rsp.read_data);
          check_field("rx_irq", 16'(want.rx_irq), 16'(rsp.rx_irq));
          check_field("tx_irq", 16'(want.tx_irq), 16'(rsp.tx_irq));
          check_field("tx_start", 16'(want.tx_start), 16'(rsp.tx_start));
          check_field("tx_char_valid", 16'(want.tx_char_valid), 16'(rsp.tx_char_valid));
          check_field("tx_char", 16'(want.tx_char), 16'(rsp.tx_char));
        end
      end
    end
    fail_count  <= errors;
    outstanding <= reply_q.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the serial line unit registers: clock, reset, stimulus and verdict.
module tb_top;
  import slu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 210;

  // Register addresses.
  localparam logic [2:0] RX_STAT     = 3'd0;
  localparam logic [2:0] RX_STAT_ODD = 3'd1;
  localparam logic [2:0] RX_BUF      = 3'd2;
  localparam logic [2:0] TX_STAT     = 3'd4;
  localparam logic [2:0] TX_STAT_ODD = 3'd5;
  localparam logic [2:0] TX_BUF      = 3'd6;
  localparam logic [2:0] TX_BUF_ODD  = 3'd7;

  localparam logic [15:0] IE_ON = 16'(1) << STAT_IE_BIT;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  int   fail_count;
  int   outstanding;
  int   cycles = 0;
  bit   steady = 1'b0;

  slu_cmd_if cmd_ch ();
  slu_rsp_if rsp_ch ();

  serial_line_unit_registers_top dut (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  slu_reg_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none at all during a steady stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  task automatic send(func_t f, logic [2:0] a, logic [15:0] d, logic [7:0] ch, logic brk);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.func       <= f;
    cmd_ch.addr       <= a;
    cmd_ch.write_data <= d;
    cmd_ch.rx_char    <= ch;
    cmd_ch.rx_break   <= brk;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Holds off the command side until every response has come back.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(logic eight);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= eight;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One random transaction, or a short well-formed sequence of two.
  task automatic random_step(output int n);
    int pick;
    int r;
    func_t f;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send(FUNC_WRITE, TX_BUF | 3'($urandom_range(1)), 16'($urandom), 8'($urandom),
           1'($urandom));
      send(FUNC_TX_DONE, 3'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
      n = 2;
    end else if (pick < 22) begin
      send(FUNC_RX_CHAR, 3'($urandom), 16'($urandom), 8'($urandom),
           1'($urandom_range(7) == 0));
      send(FUNC_READ, $urandom_range(1) ? RX_BUF : RX_STAT, 16'($urandom), 8'($urandom),
           1'($urandom));
      n = 2;
    end else begin
      r = $urandom_range(99);
      if (r < 35) begin
        f = FUNC_READ;
      end else if (r < 65) begin
        f = FUNC_WRITE;
      end else if (r < 80) begin
        f = FUNC_RX_CHAR;
      end else begin
        f = FUNC_TX_DONE;
      end
      send(f, 3'($urandom), 16'($urandom), 8'($urandom), 1'($urandom_range(7) == 0));
      n = 1;
    end
  endtask

  // Response side: ready held for a while, then dropped for a random stall.
  initial begin
    int hold;
    int stall;
    rsp_ch.ready = 1'b0;
    forever begin
      hold  = ($urandom_range(9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      stall = ($urandom_range(19) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 2);
      @(posedge clk) rsp_ch.ready <= 1'b1;
      repeat (hold) @(posedge clk);
      rsp_ch.ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
  end

  initial begin
    int sent;
    int n;
    cmd_ch.valid      = 1'b0;
    cmd_ch.func       = FUNC_READ;
    cmd_ch.addr       = '0;
    cmd_ch.write_data = '0;
    cmd_ch.rx_char    = '0;
    cmd_ch.rx_break   = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, seven-bit mode.
    set_mode(1'b0);
    send(FUNC_READ, RX_STAT, 16'h0000, 8'h00, 1'b0);
    send(FUNC_READ, TX_STAT, 16'hFFFF, 8'hFF, 1'b1);
    send(FUNC_READ, RX_BUF, 16'h0000, 8'h00, 1'b0);
    send(FUNC_READ, TX_BUF, 16'h0000, 8'h00, 1'b0);
    send(FUNC_WRITE, RX_STAT_ODD, 16'hFFFF, 8'h00, 1'b0);
    send(FUNC_WRITE, RX_STAT, IE_ON, 8'h00, 1'b0);
    send(FUNC_RX_CHAR, RX_STAT, 16'h0000, 8'hFF, 1'b0);
    send(FUNC_READ, RX_STAT, 16'h0000, 8'h00, 1'b0);
    send(FUNC_READ, RX_BUF, 16'h0000, 8'h00, 1'b0);
    send(FUNC_RX_CHAR, RX_STAT, 16'h0000, 8'hAA, 1'b1);
    send(FUNC_WRITE, RX_BUF, 16'hFFFF, 8'h00, 1'b0);
    send(FUNC_TX_DONE, TX_STAT, 16'h0000, 8'h00, 1'b0);
    send(FUNC_WRITE, TX_BUF, 16'hFFFF, 8'h00, 1'b0);
    send(FUNC_WRITE, TX_STAT, IE_ON, 8'h00, 1'b0);
    send(FUNC_TX_DONE, TX_STAT, 16'h0000, 8'h00, 1'b0);
    send(FUNC_WRITE, TX_STAT, 16'h0000, 8'h00, 1'b0);
    // Enabling while done is already set raises the request at once.
    send(FUNC_WRITE, TX_STAT, IE_ON, 8'h00, 1'b0);
    send(FUNC_WRITE, TX_STAT_ODD, 16'h0000, 8'h00, 1'b0);
    send(FUNC_WRITE, TX_BUF_ODD, 16'h0000, 8'h00, 1'b0);
    send(FUNC_WRITE, TX_BUF, 16'h1234, 8'h00, 1'b0);
    send(FUNC_TX_DONE, TX_BUF, 16'h0000, 8'h00, 1'b0);
    send(FUNC_TX_DONE, TX_BUF, 16'h0000, 8'h00, 1'b0);
    send(FUNC_WRITE, RX_STAT, ~IE_ON, 8'h00, 1'b0);

    // Eight-bit mode keeps the top data bit on both sides.
    set_mode(1'b1);
    send(FUNC_RX_CHAR, RX_BUF, 16'h0000, 8'hFF, 1'b0);
    send(FUNC_WRITE, TX_BUF, 16'hFF80, 8'h00, 1'b0);
    send(FUNC_TX_DONE, TX_BUF, 16'h0000, 8'h00, 1'b0);

    for (int phase = 0; phase < 6; phase++) begin
      set_mode(1'((phase + 1) % 2));
      steady = (phase == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        random_step(n);
        sent += n;
        // Pause mid-phase once until the pipeline runs dry.
        if (phase == 3 && sent >= PHASE_ITEMS / 2 && sent - n < PHASE_ITEMS / 2) begin
          settle();
        end
      end
    end
    steady = 1'b0;

    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
sv/slu_pkg.sv
sv/slu_if.sv
sv/slu_core.sv
sv/serial_line_unit_registers_top.sv
dv/slu_reg_checker.sv
dv/tb_top.sv
